[sv/heightmap_smooth_normals_unit_macros.svh]
// Assertion macros for the heightmap smoothing and normal unit.
// Included by RTL files that carry concurrent checks; clocked on clk, reset by arst_n.
`ifndef HEIGHTMAP_SMOOTH_NORMALS_UNIT_MACROS_SVH
`define HEIGHTMAP_SMOOTH_NORMALS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("hsn check failed");
`define HSN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("hsn check failed");
`else
`define HSN_ASSERT_IMP(label, ante, cons)
`define HSN_ASSERT_NXT(label, ante, cons)
`endif
`endif

[sv/hsn_pkg.sv]
// Shared constants, types and helpers of the heightmap smoothing and normal unit.
// No dependencies; used by every module of the block.
package hsn_pkg;

	localparam int MAX_SIDE   = 512;
	localparam int FRAC_BITS  = 12;
	localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int RAW_W      = 8;
	localparam int SH_W       = RAW_W + FRAC_BITS;
	localparam int SUM3_W     = SH_W + 2;
	localparam int DZ_W       = SH_W + 1;
	localparam int SQ_W       = 2 * SH_W;
	localparam int NSUM_W     = SQ_W + 2;
	localparam int NORM_W     = 16;
	localparam int NZ_W       = 15;
	localparam int QBITS      = 15;
	localparam int QUOT_W     = 2 * QBITS + 1;
	localparam int ROOT_W     = QBITS + 1;
	localparam int SIDE_RESET = 257;
	localparam int SIDE_MIN   = 2;

	typedef logic [1:0] m3_t;

	// One queued item: the raw sample and whether it carries a sample at all.
	typedef struct packed {
		logic [RAW_W-1:0] height;
		logic             is_sample;
	} item_t;

	typedef struct packed {
		logic                   start;
		logic signed [DZ_W-1:0] dzx;
		logic signed [DZ_W-1:0] dzy;
	} norm_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic [NZ_W-1:0]          nz;
	} norm_rsp_t;

	function automatic m3_t m3_inc(input m3_t v);
		return (v == 2'd2) ? 2'd0 : m3_t'(v + 2'd1);
	endfunction

	function automatic m3_t m3_dec(input m3_t v);
		return (v == 2'd0) ? 2'd2 : m3_t'(v - 2'd1);
	endfunction

endpackage

[sv/heightmap_smooth_normals_unit.sv]
// Top level of the heightmap smoothing and normal unit: front queue and back end.
// Depends on hsn_pkg, hsn_front and hsn_back (which holds hsn_norm).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid / in_ready  | height, padding
//   result   | out_valid / out_ready| pos_x, pos_y, smoothed_height, normal_x/y/z, last
//   config   | cfg_we (no wait)     | cfg_wdata (side_length)
//
// Each queued item is dequeued, then runs the smoothing steps that it allows (usually one step
// per sample, a whole column at the end of the map) and a check for a vertex.
// An emitted vertex also runs the shared divide and square-root unit over three components,
// each with 31 divide and 16 root steps plus load and store.
// Reset clears all counters and control; the column stores need no clearing.
// A stalled result holds the output register; the two-entry queue keeps taking transfers until it is full.
module heightmap_smooth_normals_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [9:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         height,
	input  logic               padding,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [8:0]         pos_x,
	output logic [8:0]         pos_y,
	output logic [19:0]        smoothed_height,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic [14:0]        normal_z,
	output logic               last
);

	hsn_pkg::item_t item;
	logic           item_valid;
	logic           pop;

	hsn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.height     (height),
		.padding    (padding),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	hsn_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.item_valid      (item_valid),
		.item            (item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.smoothed_height (smoothed_height),
		.normal_x        (normal_x),
		.normal_y        (normal_y),
		.normal_z        (normal_z),
		.last            (last)
	);

endmodule

[sv/hsn_front.sv]
// Input side: takes transfers, classifies them and holds them in a two-entry queue.
// Depends on hsn_pkg for the queued item type.
module hsn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         height,
	input  logic               padding,
	input  logic               pop,
	output logic               item_valid,
	output hsn_pkg::item_t     item
);

	hsn_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           take;

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != 2'd0);
	assign take       = pop && item_valid;
	assign item       = fifo_q[rd_ptr_q];

	// Queue storage; a padding transfer is marked as carrying no sample.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].height    <= height;
			fifo_q[wr_ptr_q].is_sample <= !padding;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			if (push && !take) count_q <= count_q + 2'd1;
			else if (take && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

[sv/hsn_norm.sv]
// Normalisation unit: squares, sum, then a restoring divide and an integer square root,
// shared over the three components. Depends on hsn_pkg for widths and request types.
module hsn_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  hsn_pkg::norm_req_t req,
	output hsn_pkg::norm_rsp_t rsp
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SQ    = 3'd1;
	localparam logic [2:0] N_SUM   = 3'd2;
	localparam logic [2:0] N_LOAD  = 3'd3;
	localparam logic [2:0] N_DIV   = 3'd4;
	localparam logic [2:0] N_SQRT  = 3'd5;
	localparam logic [2:0] N_STORE = 3'd6;
	localparam logic [2:0] N_DONE  = 3'd7;

	localparam logic [hsn_pkg::SQ_W-1:0] ONE_SQ = hsn_pkg::SQ_W'(1) << (2 * hsn_pkg::FRAC_BITS);

	logic [2:0]                             state_q;
	logic signed [hsn_pkg::DZ_W-1:0]        dzx_q, dzy_q;
	logic [hsn_pkg::SQ_W-1:0]               sqx_q, sqy_q;
	logic [hsn_pkg::NSUM_W-1:0]             sum_q;
	logic [1:0]                             comp_q;
	logic [hsn_pkg::NSUM_W-1:0]             rem_q;
	logic [hsn_pkg::QUOT_W-1:0]             dl_q;
	logic [hsn_pkg::QUOT_W-1:0]             quot_q;
	logic [4:0]                             cnt_q;
	logic [hsn_pkg::ROOT_W-1:0]             root_q;
	logic [3:0]                             bit_q;
	logic signed [hsn_pkg::NORM_W-1:0]      nx_q, ny_q;
	logic [hsn_pkg::NZ_W-1:0]               nz_q;

	logic [hsn_pkg::SH_W-1:0]               magx, magy;
	logic [hsn_pkg::SQ_W-1:0]               m2;
	logic [hsn_pkg::NSUM_W:0]               rr;
	logic                                   ge;
	logic [hsn_pkg::ROOT_W-1:0]             trial;
	logic [2*hsn_pkg::ROOT_W-1:0]           trial_sq;
	logic [hsn_pkg::NZ_W-1:0]               val;
	logic signed [hsn_pkg::NORM_W-1:0]      val_neg;

	// Magnitudes of the differences and the square chosen for the current component.
	always_comb begin
		magx = dzx_q[hsn_pkg::DZ_W-1] ? hsn_pkg::SH_W'(-dzx_q) : hsn_pkg::SH_W'(dzx_q);
		magy = dzy_q[hsn_pkg::DZ_W-1] ? hsn_pkg::SH_W'(-dzy_q) : hsn_pkg::SH_W'(dzy_q);
		case (comp_q)
			2'd0:    m2 = sqx_q;
			2'd1:    m2 = sqy_q;
			default: m2 = ONE_SQ;
		endcase
	end

	// One quotient bit and one root bit per cycle.
	always_comb begin
		rr       = {rem_q, dl_q[hsn_pkg::QUOT_W-1]};
		ge       = (rr >= {1'b0, sum_q});
		trial    = root_q | (hsn_pkg::ROOT_W'(1) << bit_q);
		trial_sq = trial * trial;
		val      = root_q[hsn_pkg::ROOT_W-1] ? {hsn_pkg::NZ_W{1'b1}} : root_q[hsn_pkg::NZ_W-1:0];
		val_neg  = hsn_pkg::NORM_W'(0) - hsn_pkg::NORM_W'(val);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (req.start) begin
					dzx_q <= req.dzx;
					dzy_q <= req.dzy;
				end
			end
			N_SQ: begin
				sqx_q <= hsn_pkg::SQ_W'(magx) * hsn_pkg::SQ_W'(magx);
				sqy_q <= hsn_pkg::SQ_W'(magy) * hsn_pkg::SQ_W'(magy);
			end
			N_SUM: begin
				sum_q <= hsn_pkg::NSUM_W'(sqx_q) + hsn_pkg::NSUM_W'(sqy_q)
					+ hsn_pkg::NSUM_W'(ONE_SQ);
			end
			N_LOAD: begin
				rem_q  <= hsn_pkg::NSUM_W'(m2 >> 1);
				dl_q   <= {m2[0], {(hsn_pkg::QUOT_W-1){1'b0}}};
				quot_q <= '0;
				cnt_q  <= 5'(hsn_pkg::QUOT_W - 1);
			end
			N_DIV: begin
				rem_q  <= ge ? hsn_pkg::NSUM_W'(rr - {1'b0, sum_q}) : rr[hsn_pkg::NSUM_W-1:0];
				dl_q   <= {dl_q[hsn_pkg::QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[hsn_pkg::QUOT_W-2:0], ge};
				cnt_q  <= cnt_q - 5'd1;
				root_q <= '0;
				bit_q  <= 4'(hsn_pkg::ROOT_W - 1);
			end
			N_SQRT: begin
				if (trial_sq <= {1'b0, quot_q}) root_q <= trial;
				bit_q <= bit_q - 4'd1;
			end
			N_STORE: begin
				case (comp_q)
					2'd0:    nx_q <= (!dzx_q[hsn_pkg::DZ_W-1] && (dzx_q != '0)) ? val_neg
						: hsn_pkg::NORM_W'(val);
					2'd1:    ny_q <= (!dzy_q[hsn_pkg::DZ_W-1] && (dzy_q != '0)) ? val_neg
						: hsn_pkg::NORM_W'(val);
					default: nz_q <= val;
				endcase
			end
			default: begin
			end
		endcase
	end

	// Sequencer over the three components.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			comp_q  <= 2'd0;
		end else begin
			unique case (state_q)
				N_IDLE:  if (req.start) state_q <= N_SQ;
				N_SQ:    state_q <= N_SUM;
				N_SUM: begin
					comp_q  <= 2'd0;
					state_q <= N_LOAD;
				end
				N_LOAD:  state_q <= N_DIV;
				N_DIV:   if (cnt_q == 5'd0) state_q <= N_SQRT;
				N_SQRT:  if (bit_q == 4'd0) state_q <= N_STORE;
				N_STORE: begin
					if (comp_q == 2'd2) begin
						state_q <= N_DONE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= N_LOAD;
					end
				end
				N_DONE:  state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == N_DONE);
	assign rsp.nx   = nx_q;
	assign rsp.ny   = ny_q;
	assign rsp.nz   = nz_q;

endmodule

[sv/hsn_back.sv]
// Back end: column stores, in-place smoothing sequencer, emission and output register.
// Depends on hsn_pkg, the assertion macros and the normalisation unit hsn_norm.
`include "heightmap_smooth_normals_unit_macros.svh"
module hsn_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [9:0]               cfg_wdata,
	input  logic                     item_valid,
	input  hsn_pkg::item_t           item,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [8:0]               pos_x,
	output logic [8:0]               pos_y,
	output logic [19:0]              smoothed_height,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic [14:0]              normal_z,
	output logic                     last
);

	localparam int SW   = hsn_pkg::SIDE_W;
	localparam int CW   = hsn_pkg::COORD_W;
	localparam int RAW_DEPTH = 2 * hsn_pkg::MAX_SIDE;
	localparam int SM_DEPTH  = 3 * hsn_pkg::MAX_SIDE;
	localparam int RAW_AW    = CW + 1;
	localparam int SM_AW     = CW + 2;
	localparam logic [22:0] DIV3_MUL = 23'd5592406;

	localparam logic [3:0] B_IDLE   = 4'd0;
	localparam logic [3:0] B_SMA    = 4'd1;
	localparam logic [3:0] B_SMB    = 4'd2;
	localparam logic [3:0] B_SMC    = 4'd3;
	localparam logic [3:0] B_EMCHK  = 4'd4;
	localparam logic [3:0] B_EM1    = 4'd5;
	localparam logic [3:0] B_EM2    = 4'd6;
	localparam logic [3:0] B_EMWAIT = 4'd7;
	localparam logic [3:0] B_EMOUT  = 4'd8;

	// Truncating divide by three of a sum of three heights, by reciprocal multiply.
	function automatic logic [hsn_pkg::SH_W-1:0] div3(input logic [hsn_pkg::SUM3_W-1:0] n);
		logic [44:0] p;
		p = 45'(n) * 45'(DIV3_MUL);
		return p[24 +: hsn_pkg::SH_W];
	endfunction

	logic [hsn_pkg::RAW_W-1:0] raw_mem [RAW_DEPTH];
	logic [hsn_pkg::SH_W-1:0]  sm_mem  [SM_DEPTH];

	logic [3:0]              state_q;
	logic [SW-1:0]           side_q;
	logic [SW-1:0]           in_x_q, sm_x_q;
	logic [CW-1:0]           in_y_q, sm_y_q, out_x_q, out_y_q;
	hsn_pkg::m3_t            sm_m3_q, out_m3_q;
	logic [hsn_pkg::SH_W-1:0] h_q, last_v_q, s00_q, s10_q, sh_q;
	logic [hsn_pkg::RAW_W-1:0] raw_rd0_q, raw_rd1_q;
	logic [hsn_pkg::SH_W-1:0] sm_rd0_q, sm_rd1_q;

	logic                    out_valid_q;
	logic [CW-1:0]           pos_x_q, pos_y_q;
	logic [hsn_pkg::SH_W-1:0] sh_out_q;
	logic signed [15:0]      nx_out_q, ny_out_q;
	logic [14:0]             nz_out_q;
	logic                    last_q;

	hsn_pkg::norm_req_t      nreq;
	hsn_pkg::norm_rsp_t      nrsp;

	logic [SW-1:0]           side_m1;
	logic [CW-1:0]           side_m1c, side_m2c;
	logic [RAW_AW-1:0]       raw_ra0, raw_ra1, raw_wa;
	logic [SM_AW-1:0]        sm_ra0, sm_ra1, sm_wa;
	logic                    raw_we, sm_we;
	logic [hsn_pkg::SH_W-1:0] sm_wd;
	logic [SW-1:0]           snx;
	logic [SW-1:0]           sny;
	logic                    can_smooth;
	logic [CW-1:0]           yp;
	hsn_pkg::m3_t            xp_m3;
	logic [SW-1:0]           enx;
	logic [CW-1:0]           eny;
	logic                    can_emit;
	logic                    int_x, int_y;
	logic [hsn_pkg::SUM3_W-1:0] hsum, vsum;
	logic [hsn_pkg::SH_W-1:0] h_new, v_new;
	logic                    is_last;
	logic                    load_out;
	logic [SW-1:0]           clamp_side;

	assign side_m1  = side_q - SW'(1);
	assign side_m1c = side_m1[CW-1:0];
	assign side_m2c = CW'(side_q - SW'(2));

	// Smoothing lookahead: the raw samples below and to the right must be in.
	always_comb begin
		if (sm_x_q < side_m1) begin
			snx = sm_x_q + SW'(1);
			sny = SW'(sm_y_q);
		end else if (sm_y_q < side_m1c) begin
			snx = sm_x_q;
			sny = SW'(sm_y_q) + SW'(1);
		end else begin
			snx = sm_x_q;
			sny = SW'(sm_y_q);
		end
		can_smooth = (sm_x_q < side_q)
			&& ((in_x_q > snx) || ((in_x_q == snx) && (SW'(in_y_q) > sny)));
	end

	// Emission: the clamped forward-difference neighbours must all be smoothed.
	always_comb begin
		yp    = (out_y_q == side_m1c) ? side_m2c : out_y_q;
		xp_m3 = (SW'(out_x_q) == side_m1) ? hsn_pkg::m3_dec(out_m3_q) : out_m3_q;
		if (SW'(out_x_q) < side_m1) begin
			enx = SW'(out_x_q) + SW'(1);
			eny = yp;
		end else begin
			enx = side_m1;
			eny = out_y_q;
		end
		can_emit = (SW'(out_x_q) < side_q)
			&& ((sm_x_q > enx) || ((sm_x_q == enx) && (sm_y_q > eny)));
		is_last  = (SW'(out_x_q) == side_m1) && (out_y_q == side_m1c);
	end

	// Memory addresses by sequencer step.
	always_comb begin
		raw_ra0 = {sm_x_q[0], sm_y_q};
		raw_ra1 = {!sm_x_q[0], sm_y_q};
		sm_ra0  = {hsn_pkg::m3_dec(sm_m3_q), sm_y_q};
		sm_ra1  = {sm_m3_q, sm_y_q};
		unique case (state_q)
			B_SMB:   raw_ra0 = {sm_x_q[0], CW'(sm_y_q + CW'(1))};
			B_EMCHK: begin
				sm_ra0 = {xp_m3, yp};
				sm_ra1 = {hsn_pkg::m3_inc(xp_m3), yp};
			end
			B_EM1: begin
				sm_ra0 = {xp_m3, CW'(yp + CW'(1))};
				sm_ra1 = {out_m3_q, out_y_q};
			end
			default: begin
			end
		endcase
	end

	// Horizontal and vertical three-tap passes.
	always_comb begin
		int_x = (sm_x_q != '0) && (sm_x_q < side_m1);
		int_y = (sm_y_q != '0) && (SW'(sm_y_q) < side_m1);
		hsum  = hsn_pkg::SUM3_W'(sm_rd0_q)
			+ hsn_pkg::SUM3_W'({raw_rd0_q, {hsn_pkg::FRAC_BITS{1'b0}}})
			+ hsn_pkg::SUM3_W'({raw_rd1_q, {hsn_pkg::FRAC_BITS{1'b0}}});
		vsum  = hsn_pkg::SUM3_W'(last_v_q) + hsn_pkg::SUM3_W'(h_q)
			+ hsn_pkg::SUM3_W'({raw_rd0_q, {hsn_pkg::FRAC_BITS{1'b0}}});
		h_new = int_x ? div3(hsum) : {raw_rd0_q, {hsn_pkg::FRAC_BITS{1'b0}}};
		v_new = int_y ? div3(vsum) : h_q;
	end

	assign pop      = (state_q == B_IDLE) && item_valid && !cfg_we;
	assign raw_we   = pop && item.is_sample && (in_x_q < side_q);
	assign raw_wa   = {in_x_q[0], in_y_q};
	assign sm_we    = (state_q == B_SMC);
	assign sm_wa    = {sm_m3_q, sm_y_q};
	assign sm_wd    = v_new;
	assign load_out = (state_q == B_EMOUT) && (!out_valid_q || out_ready) && !cfg_we;

	assign nreq.start = (state_q == B_EM2);
	assign nreq.dzx   = hsn_pkg::DZ_W'(s10_q) - hsn_pkg::DZ_W'(s00_q);
	assign nreq.dzy   = hsn_pkg::DZ_W'(sm_rd0_q) - hsn_pkg::DZ_W'(s00_q);

	hsn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.rsp    (nrsp)
	);

	// Column stores with registered read data.
	always_ff @(posedge clk) begin
		if (raw_we) raw_mem[raw_wa] <= item.height;
		raw_rd0_q <= raw_mem[raw_ra0];
		raw_rd1_q <= raw_mem[raw_ra1];
	end

	always_ff @(posedge clk) begin
		if (sm_we) sm_mem[sm_wa] <= sm_wd;
		sm_rd0_q <= sm_mem[sm_ra0];
		sm_rd1_q <= sm_mem[sm_ra1];
	end

	// Datapath holding registers.
	always_ff @(posedge clk) begin
		if (state_q == B_SMB) h_q <= h_new;
		if (sm_we) last_v_q <= v_new;
		if (state_q == B_EM1) begin
			s00_q <= sm_rd0_q;
			s10_q <= sm_rd1_q;
		end
		if (state_q == B_EM2) sh_q <= sm_rd1_q;
		if (load_out) begin
			pos_x_q  <= out_x_q;
			pos_y_q  <= out_y_q;
			sh_out_q <= sh_q;
			nx_out_q <= nrsp.nx;
			ny_out_q <= nrsp.ny;
			nz_out_q <= nrsp.nz;
			last_q   <= is_last;
		end
	end

	always_comb begin
		if (cfg_wdata < SW'(hsn_pkg::SIDE_MIN)) clamp_side = SW'(hsn_pkg::SIDE_MIN);
		else if (cfg_wdata > SW'(hsn_pkg::MAX_SIDE)) clamp_side = SW'(hsn_pkg::MAX_SIDE);
		else clamp_side = cfg_wdata;
	end

	// Output valid: set when a result is loaded, cleared once it has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			side_q      <= SW'(hsn_pkg::SIDE_RESET);
			in_x_q      <= '0;
			in_y_q      <= '0;
			sm_x_q      <= '0;
			sm_y_q      <= '0;
			sm_m3_q     <= '0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_m3_q    <= '0;
		end else begin
			if (cfg_we) begin
				side_q   <= clamp_side;
				in_x_q   <= '0;
				in_y_q   <= '0;
				sm_x_q   <= '0;
				sm_y_q   <= '0;
				sm_m3_q  <= '0;
				out_x_q  <= '0;
				out_y_q  <= '0;
				out_m3_q <= '0;
			end else begin
				unique case (state_q)
					B_IDLE: begin
						if (pop) begin
							if (raw_we) begin
								if (SW'(in_y_q) + SW'(1) == side_q) begin
									in_y_q <= '0;
									in_x_q <= in_x_q + SW'(1);
								end else begin
									in_y_q <= in_y_q + CW'(1);
								end
							end
							state_q <= B_SMA;
						end
					end
					B_SMA:   state_q <= can_smooth ? B_SMB : B_EMCHK;
					B_SMB:   state_q <= B_SMC;
					B_SMC: begin
						if (SW'(sm_y_q) + SW'(1) == side_q) begin
							sm_y_q  <= '0;
							sm_x_q  <= sm_x_q + SW'(1);
							sm_m3_q <= hsn_pkg::m3_inc(sm_m3_q);
						end else begin
							sm_y_q <= sm_y_q + CW'(1);
						end
						state_q <= B_SMA;
					end
					B_EMCHK: state_q <= can_emit ? B_EM1 : B_IDLE;
					B_EM1:   state_q <= B_EM2;
					B_EM2:   state_q <= B_EMWAIT;
					B_EMWAIT: if (nrsp.done) state_q <= B_EMOUT;
					B_EMOUT: begin
						if (load_out) begin
							if (is_last) begin
								in_x_q   <= '0;
								in_y_q   <= '0;
								sm_x_q   <= '0;
								sm_y_q   <= '0;
								sm_m3_q  <= '0;
								out_x_q  <= '0;
								out_y_q  <= '0;
								out_m3_q <= '0;
							end else if (SW'(out_y_q) + SW'(1) == side_q) begin
								out_y_q  <= '0;
								out_x_q  <= out_x_q + CW'(1);
								out_m3_q <= hsn_pkg::m3_inc(out_m3_q);
							end else begin
								out_y_q <= out_y_q + CW'(1);
							end
							state_q <= B_IDLE;
						end
					end
					default: state_q <= B_IDLE;
				endcase
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign pos_x           = pos_x_q;
	assign pos_y           = pos_y_q;
	assign smoothed_height = sh_out_q;
	assign normal_x        = nx_out_q;
	assign normal_y        = ny_out_q;
	assign normal_z        = nz_out_q;
	assign last            = last_q;

	// A result is only loaded into a free or draining output register.
	`HSN_ASSERT_IMP(a_load_free, load_out, !out_valid_q || out_ready)
	// Smoothing never runs past the received map.
	`HSN_ASSERT_IMP(a_sm_in_map, sm_we, (sm_x_q < side_q) && (sm_x_q <= in_x_q))
	// Emission never overtakes the smoothing position.
	`HSN_ASSERT_IMP(a_emit_behind, state_q == B_EM1, sm_x_q >= SW'(out_x_q))

endmodule

[bench/tb_heightmap_smooth_normals_unit.sv]
// Self-checking testbench for heightmap_smooth_normals_unit: directed frames from a table, checked
// against its tabled vertices, then random frames of many sizes, checked against an in-bench vertex predictor.
// Depends on hsn_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_heightmap_smooth_normals_unit;

	localparam int ITEM_GOAL   = 1250;
	localparam int IDLE_PCT    = 34;
	localparam int SETTLE_CYC  = 2000;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int NZ_FLAT     = 32767;
	localparam int HOLD_CYC    = 2000;

	typedef struct {
		logic [8:0]         x;
		logic [8:0]         y;
		logic [19:0]        sh;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [14:0]        nz;
		logic               lst;
	} vertex_t;

	typedef struct {
		bit [7:0]  h;
		bit        pad;
		bit        typed;
		bit [8:0]  x;
		bit [8:0]  y;
		bit [19:0] sh;
		bit        lst;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [9:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         height;
	logic               padding;
	logic               out_valid;
	logic               out_ready;
	logic [8:0]         pos_x;
	logic [8:0]         pos_y;
	logic [19:0]        smoothed_height;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic [14:0]        normal_z;
	logic               last;

	heightmap_smooth_normals_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .height(height), .padding(padding),
		.out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
		.smoothed_height(smoothed_height), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .last(last)
	);

	// Predictor state: its own copy of the column stores, counters and side register.
	logic [7:0]  raw_store [2*hsn_pkg::MAX_SIDE];
	logic [19:0] smooth_store [3*hsn_pkg::MAX_SIDE];
	int unsigned side_reg;
	int unsigned in_x, in_y, out_x, out_y, sm_x, sm_y;

	vertex_t vertex_q [$];
	int      mismatches;
	int      items_sent;
	int      vertices_seen;
	int      frames_done;
	int      cycles;
	int      hold_left;
	bit      quiet;
	bit      held;

	// Clock and cycle limit.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int unsigned eff_side();
		if (side_reg < hsn_pkg::SIDE_MIN) return hsn_pkg::SIDE_MIN;
		if (side_reg > hsn_pkg::MAX_SIDE) return hsn_pkg::MAX_SIDE;
		return side_reg;
	endfunction

	function automatic longint raw_fix(int unsigned a, int unsigned b);
		return longint'(raw_store[(a & 1) * hsn_pkg::MAX_SIDE + b]) << hsn_pkg::FRAC_BITS;
	endfunction

	function automatic int unsigned sm_idx(int unsigned a, int unsigned b);
		return (a % 3) * hsn_pkg::MAX_SIDE + b;
	endfunction

	// Largest q below 2^15 with q * sqrt(sum) <= 32768 * mag, by exact squares.
	function automatic logic [14:0] unit_quot(longint unsigned mag, longint unsigned sum);
		logic [127:0] lim;
		logic [127:0] prod;
		logic [14:0]  q;
		logic [14:0]  t;
		lim = ({64'd0, mag} * mag) << 30;
		q = '0;
		for (int b = 14; b >= 0; b--) begin
			t = q | (15'd1 << b);
			prod = 128'(t) * 128'(t) * 128'(sum);
			if (prod <= lim) q = t;
		end
		return q;
	endfunction

	function automatic logic signed [15:0] signed_quot(longint comp, longint unsigned sum);
		logic [14:0] q;
		q = unit_quot(comp < 0 ? -comp : comp, sum);
		return comp < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	// Two-pass in-place smoothing of one position.
	task automatic smooth_cell(int unsigned a, int unsigned b, int unsigned side);
		longint hv;
		longint vv;
		hv = raw_fix(a, b);
		if (a > 0 && a < side - 1)
			hv = (longint'(smooth_store[sm_idx(a - 1, b)]) + hv + raw_fix(a + 1, b)) / 3;
		vv = hv;
		if (b > 0 && b < side - 1)
			vv = (longint'(smooth_store[sm_idx(a, b - 1)]) + hv + raw_fix(a, b + 1)) / 3;
		smooth_store[sm_idx(a, b)] = vv[19:0];
	endtask

	function automatic void restart_frame();
		in_x = 0; in_y = 0; out_x = 0; out_y = 0; sm_x = 0; sm_y = 0;
	endfunction

	// Advance the predictor by one accepted item; got is set when a vertex results.
	task automatic predict_vertex(input logic [7:0] h, input logic pad,
			output bit got, output vertex_t v);
		int unsigned side, total, rcount, scount, need, xp, yp;
		longint dzx, dzy, one;
		longint unsigned sum;
		side = eff_side();
		total = side * side;
		one = longint'(1) << hsn_pkg::FRAC_BITS;
		got = 0;
		if (!pad && in_x < side) begin
			raw_store[(in_x & 1) * hsn_pkg::MAX_SIDE + in_y] = h;
			in_y++;
			if (in_y == side) begin
				in_y = 0;
				in_x++;
			end
		end
		rcount = in_x * side + in_y;
		while (sm_x < side) begin
			if (sm_x < side - 1) need = (sm_x + 1) * side + sm_y;
			else if (sm_y < side - 1) need = sm_x * side + sm_y + 1;
			else need = sm_x * side + sm_y;
			if (rcount <= need) break;
			smooth_cell(sm_x, sm_y, side);
			sm_y++;
			if (sm_y == side) begin
				sm_y = 0;
				sm_x++;
			end
		end
		scount = sm_x * side + sm_y;
		if (out_x >= side) return;
		xp = out_x < side - 2 ? out_x : side - 2;
		yp = out_y < side - 2 ? out_y : side - 2;
		need = out_x < side - 1 ? (out_x + 1) * side + yp : (side - 1) * side + out_y;
		if (scount <= need || scount > total) return;
		dzx = longint'(smooth_store[sm_idx(xp + 1, yp)]) - longint'(smooth_store[sm_idx(xp, yp)]);
		dzy = longint'(smooth_store[sm_idx(xp, yp + 1)]) - longint'(smooth_store[sm_idx(xp, yp)]);
		sum = dzx * dzx + dzy * dzy + one * one;
		got = 1;
		v.x = out_x[8:0];
		v.y = out_y[8:0];
		v.sh = smooth_store[sm_idx(out_x, out_y)];
		v.nx = signed_quot(-dzx, sum);
		v.ny = signed_quot(-dzy, sum);
		v.nz = unit_quot(one, sum);
		v.lst = (out_x == side - 1 && out_y == side - 1);
		if (v.lst) begin
			restart_frame();
		end else begin
			out_y++;
			if (out_y == side) begin
				out_y = 0;
				out_x++;
			end
		end
	endtask

	// Offer one item, wait for its transfer, then predict; returns whether it closed a frame.
	task automatic send_item(input logic [7:0] h, input logic pad, input bit typed,
			input vertex_t tv, output bit closed);
		bit      got;
		vertex_t v;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		height <= h;
		padding <= pad;
		do @(posedge clk); while (!in_ready);
		predict_vertex(h, pad, got, v);
		items_sent++;
		closed = got && v.lst;
		if (typed) begin
			if (!got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Predictor gave no vertex where one is tabled (%0d,%0d)",
						tv.x, tv.y);
			end
			vertex_q = {vertex_q, tv};
		end else if (got) begin
			vertex_q = {vertex_q, v};
		end
		if (closed) frames_done++;
		@(negedge clk);
	endtask

	// Write the side register once the block has drained.
	task automatic write_side(input logic [9:0] val);
		in_valid <= 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		side_reg = val;
		restart_frame();
	endtask

	// One well-formed frame with random content; surplus samples mixed into the drain.
	task automatic run_frame(input int unsigned side);
		bit      closed;
		vertex_t nv;
		logic [7:0] h;
		int      pick;
		closed = 0;
		for (int i = 0; i < side * side && !closed; i++) begin
			pick = $urandom_range(9);
			h = pick == 0 ? 8'd0 : pick == 1 ? 8'd255 : 8'($urandom);
			send_item(h, 1'b0, 0, nv, closed);
		end
		while (!closed)
			send_item(8'($urandom), 1'($urandom), 0, nv, closed);
	endtask

	// Receiver: random back-pressure, with a long hold counted down in its own process.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			vertices_seen++;
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected vertex (%0d,%0d)", pos_x, pos_y);
			end else begin
				e = vertex_q.pop_front();
				if (pos_x !== e.x || pos_y !== e.y || smoothed_height !== e.sh ||
						normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
						last !== e.lst) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Vertex mismatch: expected (%0d,%0d) h=%0d n=(%0d,%0d,%0d) l=%0b",
							e.x, e.y, e.sh, e.nx, e.ny, e.nz, e.lst);
						$display("                 got      (%0d,%0d) h=%0d n=(%0d,%0d,%0d) l=%0b",
							pos_x, pos_y, smoothed_height, normal_x, normal_y, normal_z, last);
					end
				end
			end
		end
	end

	// Directed table: flat 2x2 frames at both height extremes, where every normal is vertical.
	row_t flat_rows [] = '{
		'{8'd0,   1'b1, 0, 0, 0, 0,       0},
		'{8'd0,   1'b0, 0, 0, 0, 0,       0},
		'{8'd0,   1'b0, 0, 0, 0, 0,       0},
		'{8'd0,   1'b0, 0, 0, 0, 0,       0},
		'{8'd0,   1'b0, 1, 0, 0, 0,       0},
		'{8'd0,   1'b1, 1, 0, 1, 0,       0},
		'{8'd255, 1'b0, 1, 1, 0, 0,       0},
		'{8'd0,   1'b1, 1, 1, 1, 0,       1},
		'{8'd255, 1'b0, 0, 0, 0, 0,       0},
		'{8'd255, 1'b0, 0, 0, 0, 0,       0},
		'{8'd255, 1'b0, 0, 0, 0, 0,       0},
		'{8'd255, 1'b0, 1, 0, 0, 1044480, 0},
		'{8'd0,   1'b1, 1, 0, 1, 1044480, 0},
		'{8'd0,   1'b1, 1, 1, 0, 1044480, 0},
		'{8'd0,   1'b1, 1, 1, 1, 1044480, 1}
	};

	initial begin
		bit      closed;
		vertex_t tv;
		int unsigned side;
		cycles = 0;
		mismatches = 0;
		items_sent = 0;
		vertices_seen = 0;
		frames_done = 0;
		hold_left = 0;
		quiet = 0;
		held = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		height = '0;
		padding = 1'b0;
		out_ready = 1'b0;
		for (int i = 0; i < 2 * hsn_pkg::MAX_SIDE; i++) raw_store[i] = '0;
		for (int i = 0; i < 3 * hsn_pkg::MAX_SIDE; i++) smooth_store[i] = '0;
		side_reg = hsn_pkg::SIDE_RESET;
		restart_frame();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: side 2, then side 0 which acts as 2 for the bright frame.
		write_side(10'd2);
		foreach (flat_rows[i]) begin
			if (i == 8) write_side(10'd0);
			tv.x = flat_rows[i].x;
			tv.y = flat_rows[i].y;
			tv.sh = flat_rows[i].sh;
			tv.nx = 0;
			tv.ny = 0;
			tv.nz = NZ_FLAT;
			tv.lst = flat_rows[i].lst;
			send_item(flat_rows[i].h, flat_rows[i].pad, flat_rows[i].typed, tv, closed);
		end

		// Largest sides: partial frames, abandoned by a register write; then side 1, which acts as 2, for one whole frame.
		write_side(10'd1023);
		repeat (40) send_item(8'($urandom), 1'b0, 0, tv, closed);
		write_side(10'd512);
		repeat (30) send_item(8'($urandom), 1'b0, 0, tv, closed);
		write_side(10'd1);
		run_frame(2);
		write_side(10'd257);
		repeat (20) send_item(8'($urandom), 1'($urandom), 0, tv, closed);

		// Random frames; mostly small sides, larger ones only while plenty of items remain.
		while (items_sent < ITEM_GOAL) begin
			if (ITEM_GOAL - items_sent > 900 && $urandom_range(99) >= 70)
				side = $urandom_range(7, 16);
			else
				side = $urandom_range(2, 6);
			write_side(10'(side));
			if (!held && frames_done >= 12) begin
				held = 1;
				hold_left = HOLD_CYC;
			end
			quiet = (frames_done >= 20 && frames_done < 28);
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, side * side + 3))
					send_item(8'($urandom), 1'($urandom_range(3) == 0), 0, tv, closed);
			end else begin
				repeat ($urandom_range(1, 3)) run_frame(side);
			end
		end
		quiet = 0;
		in_valid <= 1'b0;

		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (vertex_q.size() != 0) mismatches++;
		$display("Sent %0d items over %0d complete frames; checked %0d vertices, %0d mismatches",
			items_sent, frames_done, vertices_seen, mismatches);
		$display("Sides from 2 to 16 plus register extremes, with input and output stalls");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
